>>> rtl/core/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants of the conv2d bias relu core
// Defines item words, configuration set, queue entry and code points.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

  // default store dimensions
  localparam int DEF_MAX_SIDE   = 32;
  localparam int DEF_MAX_KERNEL = 5;
  localparam int DEF_MAX_IN_CH  = 4;
  localparam int DEF_MAX_OUT_CH = 8;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic [1:0] CMD_WR_WGT  = 2'd0;
  localparam logic [1:0] CMD_WR_BIAS = 2'd1;
  localparam logic [1:0] CMD_WR_PIX  = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_IN_CH  = 3'd0;
  localparam logic [2:0] REG_OUT_CH = 3'd1;
  localparam logic [2:0] REG_IMAGE  = 3'd2;
  localparam logic [2:0] REG_KERNEL = 3'd3;
  localparam logic [2:0] REG_STRIDE = 3'd4;

  // register reset values
  localparam logic [2:0] RST_IN_CH  = 3'd1;
  localparam logic [3:0] RST_OUT_CH = 4'd1;
  localparam logic [5:0] RST_IMAGE  = 6'd32;
  localparam logic [2:0] RST_KERNEL = 3'd3;
  localparam logic [5:0] RST_STRIDE = 6'd1;

  // top of the result field
  localparam logic [30:0] RESULT_MAX = '1;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         in_channel;
    logic [2:0]         out_channel;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [30:0] result;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] input_channels;
    logic [3:0] output_channels;
    logic [5:0] image_size;
    logic [2:0] kernel_side;
    logic [5:0] stride;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_WGT,
    OP_BIAS,
    OP_PIX,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               bad;
    logic [1:0]         in_channel;
    logic [2:0]         out_channel;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] value;
  } queue_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/mcc_ram.sv
// ----------------------------------------------------------------------------
// mcc_ram: generic simple dual port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mcc_front.sv
// ----------------------------------------------------------------------------
// mcc_front: input side of the conv2d core
// Takes words, drops writes outside the stores, flags bad reads, queues.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_front #(
  parameter int MAX_SIDE   = mcc_pkg::DEF_MAX_SIDE,
  parameter int MAX_KERNEL = mcc_pkg::DEF_MAX_KERNEL,
  parameter int MAX_IN_CH  = mcc_pkg::DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = mcc_pkg::DEF_MAX_OUT_CH
) (
  input  wire mcc_pkg::cfg_t         cfg,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire mcc_pkg::in_item_t     in_data,
  input  wire logic                  q_full,
  output logic                       q_push,
  output mcc_pkg::queue_entry_t      q_entry
);

  logic keep;
  logic cfg_ok;
  logic ic_ok, oc_ok;

  // configuration sanity for reads
  assign cfg_ok = (cfg.input_channels != 3'd0) && (int'(cfg.input_channels) <= MAX_IN_CH)
    && (cfg.output_channels != 4'd0) && (int'(cfg.output_channels) <= MAX_OUT_CH)
    && (cfg.image_size != 6'd0) && (int'(cfg.image_size) <= MAX_SIDE)
    && (cfg.kernel_side != 3'd0) && (int'(cfg.kernel_side) <= MAX_KERNEL)
    && ({3'd0, cfg.kernel_side} <= cfg.image_size) && (cfg.stride != 6'd0);

  assign ic_ok = int'(in_data.in_channel) < MAX_IN_CH;
  assign oc_ok = int'(in_data.out_channel) < MAX_OUT_CH;

  // classify the word
  always_comb begin
    q_entry.in_channel  = in_data.in_channel;
    q_entry.out_channel = in_data.out_channel;
    q_entry.row         = in_data.row;
    q_entry.col         = in_data.col;
    q_entry.value       = in_data.value;
    q_entry.bad         = 1'b0;
    case (in_data.command)
      mcc_pkg::CMD_WR_WGT: begin
        q_entry.op = mcc_pkg::OP_WGT;
        keep = ic_ok && oc_ok && (int'(in_data.row) < MAX_KERNEL)
          && (int'(in_data.col) < MAX_KERNEL);
      end
      mcc_pkg::CMD_WR_BIAS: begin
        q_entry.op = mcc_pkg::OP_BIAS;
        keep = oc_ok;
      end
      mcc_pkg::CMD_WR_PIX: begin
        q_entry.op = mcc_pkg::OP_PIX;
        keep = ic_ok && (int'(in_data.row) < MAX_SIDE) && (int'(in_data.col) < MAX_SIDE);
      end
      default: begin
        q_entry.op  = mcc_pkg::OP_READ;
        keep        = 1'b1;
        q_entry.bad = !cfg_ok || ({1'b0, in_data.out_channel} >= cfg.output_channels);
      end
    endcase
  end

  // a write outside the stores is taken and dropped
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

`default_nettype wire

>>> rtl/core/mcc_fifo.sv
// ----------------------------------------------------------------------------
// mcc_fifo: short queue between front and back
// Holds classified entries so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire mcc_pkg::queue_entry_t push_entry,
  input  wire logic                  pop,
  output logic                       q_valid,
  output mcc_pkg::queue_entry_t      q_entry,
  output logic                       full
);

  localparam int DEPTH = mcc_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  mcc_pkg::queue_entry_t slot_r [DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CNTW-1:0] count_r;

  assign q_valid = count_r != '0;
  assign full    = count_r == CNTW'(DEPTH);
  assign q_entry = slot_r[rptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mcc_back.sv
// ----------------------------------------------------------------------------
// mcc_back: execution side of the conv2d core
// Writes the stores and runs reads through one pipelined multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_back #(
  parameter int MAX_SIDE   = mcc_pkg::DEF_MAX_SIDE,
  parameter int MAX_KERNEL = mcc_pkg::DEF_MAX_KERNEL,
  parameter int MAX_IN_CH  = mcc_pkg::DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = mcc_pkg::DEF_MAX_OUT_CH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mcc_pkg::cfg_t         cfg,
  input  wire logic                  q_valid,
  input  wire mcc_pkg::queue_entry_t q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output mcc_pkg::out_item_t         out_data
);

  localparam int PIX_DEPTH = MAX_IN_CH * MAX_SIDE * MAX_SIDE;
  localparam int WGT_DEPTH = MAX_IN_CH * MAX_OUT_CH * MAX_KERNEL * MAX_KERNEL;
  localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int NTAP      = MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
  localparam int ACC_W     = 33 + $clog2(NTAP + 1);
  localparam int CW        = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
  localparam int KW        = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int OW        = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                   state_r;
  logic                     bad_r;
  logic [OW-1:0]            oc_r;
  logic [4:0]               row_r, col_r;
  logic [10:0]              r0_r, k0_r;
  logic [CW-1:0]            c_r;
  logic [KW-1:0]            a_r, b_r;
  logic                     v1_r, v2_r;
  logic signed [31:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [15:0]       bias_r [MAX_OUT_CH];
  logic                     out_vld_r;
  mcc_pkg::out_item_t       out_data_r;

  logic [10:0]              r0_w, k0_w;
  logic                     range_bad_w;
  logic                     last_b, last_a, last_c;
  logic                     out_free;
  logic signed [ACC_W-1:0]  bias_ext, sum_w;
  mcc_pkg::out_item_t       res_w;

  logic                     pix_we, wgt_we, run_re;
  logic [PIX_AW-1:0]        pix_waddr, pix_raddr;
  logic [WGT_AW-1:0]        wgt_waddr, wgt_raddr;
  logic [15:0]              pix_rdata, wgt_rdata;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_vld_r || !out_stall;

  // store writes straight from the queue head
  assign pix_we    = q_pop && (q_entry.op == mcc_pkg::OP_PIX);
  assign wgt_we    = q_pop && (q_entry.op == mcc_pkg::OP_WGT);
  assign pix_waddr = PIX_AW'((int'(q_entry.in_channel) * MAX_SIDE + int'(q_entry.row))
    * MAX_SIDE + int'(q_entry.col));
  assign wgt_waddr = WGT_AW'(((int'(q_entry.in_channel) * MAX_OUT_CH
    + int'(q_entry.out_channel)) * MAX_KERNEL + int'(q_entry.row)) * MAX_KERNEL
    + int'(q_entry.col));

  // tap addresses from the loop counters
  assign run_re    = state_r == S_RUN;
  assign pix_raddr = PIX_AW'((int'(c_r) * MAX_SIDE + int'(r0_r) + int'(a_r)) * MAX_SIDE
    + int'(k0_r) + int'(b_r));
  assign wgt_raddr = WGT_AW'(((int'(c_r) * MAX_OUT_CH + int'(oc_r)) * MAX_KERNEL
    + int'(a_r)) * MAX_KERNEL + int'(b_r));

  mcc_ram #(.WIDTH(16), .DEPTH(PIX_DEPTH)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (q_entry.value),
    .re    (run_re),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  mcc_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (q_entry.value),
    .re    (run_re),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  // window origin and bounds check
  assign r0_w = 11'(row_r) * 11'(cfg.stride);
  assign k0_w = 11'(col_r) * 11'(cfg.stride);
  assign range_bad_w = (12'(r0_w) + 12'(cfg.kernel_side) > 12'(cfg.image_size))
    || (12'(k0_w) + 12'(cfg.kernel_side) > 12'(cfg.image_size));

  // end of each loop level
  assign last_b = 32'(b_r) == 32'(cfg.kernel_side) - 32'd1;
  assign last_a = 32'(a_r) == 32'(cfg.kernel_side) - 32'd1;
  assign last_c = 32'(c_r) == 32'(cfg.input_channels) - 32'd1;

  // bias, relu and saturation
  assign bias_ext = ACC_W'(bias_r[oc_r]) <<< 8;
  assign sum_w    = acc_r + bias_ext;
  always_comb begin
    if (bad_r) begin
      res_w.result = '0;
      res_w.status = mcc_pkg::ST_RANGE;
    end else if (sum_w < 0) begin
      res_w.result = '0;
      res_w.status = mcc_pkg::ST_OK;
    end else if (sum_w > $signed({{(ACC_W - 31){1'b0}}, mcc_pkg::RESULT_MAX})) begin
      res_w.result = mcc_pkg::RESULT_MAX;
      res_w.status = mcc_pkg::ST_SAT;
    end else begin
      res_w.result = sum_w[30:0];
      res_w.status = mcc_pkg::ST_OK;
    end
  end

  // sequencer, mac pipeline and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      v1_r <= run_re;
      v2_r <= v1_r;
      if (v1_r) begin
        prod_r <= $signed(wgt_rdata) * $signed(pix_rdata);
      end
      if (v2_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      // output word valid: load on a finished read, clear once taken
      if (state_r == S_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_entry.op == mcc_pkg::OP_BIAS) begin
              bias_r[OW'(q_entry.out_channel)] <= q_entry.value;
            end
            if (q_entry.op == mcc_pkg::OP_READ) begin
              bad_r   <= q_entry.bad;
              oc_r    <= OW'(q_entry.out_channel);
              row_r   <= q_entry.row;
              col_r   <= q_entry.col;
              state_r <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          r0_r  <= r0_w;
          k0_r  <= k0_w;
          acc_r <= '0;
          c_r   <= '0;
          a_r   <= '0;
          b_r   <= '0;
          if (bad_r || range_bad_w) begin
            bad_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (last_b) begin
            b_r <= '0;
            if (last_a) begin
              a_r <= '0;
              if (last_c) begin
                state_r <= S_DRAIN;
              end else begin
                c_r <= c_r + 1'b1;
              end
            end else begin
              a_r <= a_r + 1'b1;
            end
          end else begin
            b_r <= b_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r <= res_w;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // mac pipeline only runs inside a read
  a_pipe_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r) |-> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("mac pipeline busy outside a read");

  // a flagged read never walks the taps
  a_bad_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !bad_r)
    else $error("bad read entered tap loop");

  // finishing a read always presents a word
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_vld_r && state_r == S_IDLE))
    else $error("finished read did not load output");

  // queue head is taken only when the back is free
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_pop)
    else $error("queue popped while busy");

endmodule

`default_nettype wire

>>> rtl/core/multichannel_conv2d_bias_relu_core.sv
// ----------------------------------------------------------------------------
// multichannel_conv2d_bias_relu_core: conv2d layer with bias and relu
// Writes: a write takes effect when it leaves the queue and gives no word.
// A read gives its word after walking every tap of its window, one kernel tap
// per cycle through the single mac.
// Throughput: one read at a time; writes drain at one per cycle between reads.
// Reset: registers return to 1, 1, 32, 3, 1; stores hold no value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_conv2d_bias_relu_core #(
  parameter int MAX_SIDE   = mcc_pkg::DEF_MAX_SIDE,
  parameter int MAX_KERNEL = mcc_pkg::DEF_MAX_KERNEL,
  parameter int MAX_IN_CH  = mcc_pkg::DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = mcc_pkg::DEF_MAX_OUT_CH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mcc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mcc_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  mcc_pkg::cfg_t         cfg_r;
  logic                  cfg_we;
  logic                  q_push, q_pop, q_valid, q_full;
  mcc_pkg::queue_entry_t push_entry, q_entry;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_channels  <= mcc_pkg::RST_IN_CH;
      cfg_r.output_channels <= mcc_pkg::RST_OUT_CH;
      cfg_r.image_size      <= mcc_pkg::RST_IMAGE;
      cfg_r.kernel_side     <= mcc_pkg::RST_KERNEL;
      cfg_r.stride          <= mcc_pkg::RST_STRIDE;
    end else if (cfg_we) begin
      case (paddr[4:2])
        mcc_pkg::REG_IN_CH:  cfg_r.input_channels  <= pwdata[2:0];
        mcc_pkg::REG_OUT_CH: cfg_r.output_channels <= pwdata[3:0];
        mcc_pkg::REG_IMAGE:  cfg_r.image_size      <= pwdata[5:0];
        mcc_pkg::REG_KERNEL: cfg_r.kernel_side     <= pwdata[2:0];
        mcc_pkg::REG_STRIDE: cfg_r.stride          <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[4:2])
      mcc_pkg::REG_IN_CH:  prdata = {29'd0, cfg_r.input_channels};
      mcc_pkg::REG_OUT_CH: prdata = {28'd0, cfg_r.output_channels};
      mcc_pkg::REG_IMAGE:  prdata = {26'd0, cfg_r.image_size};
      mcc_pkg::REG_KERNEL: prdata = {29'd0, cfg_r.kernel_side};
      mcc_pkg::REG_STRIDE: prdata = {26'd0, cfg_r.stride};
      default:             prdata = 32'd0;
    endcase
  end

  mcc_front #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_IN_CH  (MAX_IN_CH),
    .MAX_OUT_CH (MAX_OUT_CH)
  ) u_front (
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  mcc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .full       (q_full)
  );

  mcc_back #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_IN_CH  (MAX_IN_CH),
    .MAX_OUT_CH (MAX_OUT_CH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: conv2d bias relu core check
// Loads weights, biases and pixels, reads output points under several layer
// settings and compares each returned word with a local fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class conv_scoreboard;
  // local copy of layer settings and stores
  logic [2:0] n_in;
  logic [3:0] n_out;
  logic [5:0] side;
  logic [2:0] ksz;
  logic [5:0] step;
  logic signed [15:0] pix [4][32][32];
  logic signed [15:0] wgt [4][8][5][5];
  logic signed [15:0] bias [8];
  mcc_pkg::out_item_t pending [$];
  int errors;

  function new();
    n_in = mcc_pkg::RST_IN_CH; n_out = mcc_pkg::RST_OUT_CH; side = mcc_pkg::RST_IMAGE;
    ksz = mcc_pkg::RST_KERNEL; step = mcc_pkg::RST_STRIDE;
    errors = 0;
    foreach (pix[a, b, c]) pix[a][b][c] = '0;
    foreach (wgt[a, b, c, d]) wgt[a][b][c][d] = '0;
    foreach (bias[a]) bias[a] = '0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      mcc_pkg::REG_IN_CH:  n_in = val[2:0];
      mcc_pkg::REG_OUT_CH: n_out = val[3:0];
      mcc_pkg::REG_IMAGE:  side = val[5:0];
      mcc_pkg::REG_KERNEL: ksz = val[2:0];
      mcc_pkg::REG_STRIDE: step = val[5:0];
      default: ;
    endcase
  endfunction

  function bit layer_ok();
    return n_in != 0 && n_in <= 4 && n_out != 0 && n_out <= 8 && side != 0 &&
           side <= 32 && ksz != 0 && ksz <= 5 && ksz <= side && step != 0;
  endfunction

  // note an accepted input word
  function void note_word(mcc_pkg::in_item_t w);
    longint acc;
    int osz;
    mcc_pkg::out_item_t e;
    case (w.command)
      mcc_pkg::CMD_WR_WGT:
        if (w.row < 5 && w.col < 5) wgt[w.in_channel][w.out_channel][w.row][w.col] = w.value;
      mcc_pkg::CMD_WR_BIAS: bias[w.out_channel] = w.value;
      mcc_pkg::CMD_WR_PIX: pix[w.in_channel][w.row][w.col] = w.value;
      default: begin
        e.result = '0;
        e.status = mcc_pkg::ST_RANGE;
        if (layer_ok()) begin
          osz = (side - ksz) / step + 1;
          if (w.out_channel < n_out && w.row < osz && w.col < osz) begin
            acc = 0;
            for (int c = 0; c < n_in; c++)
              for (int a = 0; a < ksz; a++)
                for (int b = 0; b < ksz; b++)
                  acc += longint'(wgt[c][w.out_channel][a][b]) *
                         longint'(pix[c][w.row * step + a][w.col * step + b]);
            acc += longint'(bias[w.out_channel]) * 256;
            e.status = mcc_pkg::ST_OK;
            if (acc < 0) e.result = '0;
            else if (acc > 64'sd2147483647) begin
              e.result = mcc_pkg::RESULT_MAX;
              e.status = mcc_pkg::ST_SAT;
            end else e.result = acc[30:0];
          end
        end
        pending.push_back(e);
      end
    endcase
  endfunction

  // compare a returned word with the oldest prediction
  function void check_word(mcc_pkg::out_item_t got);
    mcc_pkg::out_item_t e;
    if (pending.size() == 0) begin
      $error("unexpected word result=%0d status=%0d", got.result, got.status);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.result !== e.result) begin
      $error("result: expected %0d actual %0d", e.result, got.result);
      errors++;
    end
    if (got.status !== e.status) begin
      $error("status: expected %0d actual %0d", e.status, got.status);
      errors++;
    end
  endfunction
endclass

module testbench;
  // pixel rows and columns loaded before any read; layers stay inside this
  localparam int FILL_SIDE = 8;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  mcc_pkg::in_item_t in_data = '0;
  logic out_valid, out_stall = 0;
  mcc_pkg::out_item_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  conv_scoreboard sb = new();
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;

  multichannel_conv2d_bias_relu_core uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: sample at rising edge, stall at falling edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
  end
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_word(mcc_pkg::in_item_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    @(negedge clk);
    in_valid <= 0;
  endtask

  function automatic mcc_pkg::in_item_t make_word(logic [1:0] cmd, int ic, int oc, int r,
                                                  int c, int v);
    mcc_pkg::in_item_t w;
    w.command = cmd; w.in_channel = 2'(ic); w.out_channel = 3'(oc);
    w.row = 5'(r); w.col = 5'(c); w.value = 16'(v);
    return w;
  endfunction

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // fill every entry that a read can reach so later reads are defined
  task automatic fill_stores(int mag);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < FILL_SIDE; r++)
        for (int k = 0; k < FILL_SIDE; k++)
          send_word(make_word(mcc_pkg::CMD_WR_PIX, c, 0, r, k,
                              $urandom_range(2 * mag) - mag));
    for (int c = 0; c < 4; c++)
      for (int o = 0; o < 8; o++)
        for (int r = 0; r < 5; r++)
          for (int k = 0; k < 5; k++)
            send_word(make_word(mcc_pkg::CMD_WR_WGT, c, o, r, k,
                                $urandom_range(2 * mag) - mag));
    for (int o = 0; o < 8; o++)
      send_word(make_word(mcc_pkg::CMD_WR_BIAS, 0, o, 0, 0, $urandom_range(2 * mag) - mag));
  endtask

  task automatic random_word(int maxpos);
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send_word(make_word(mcc_pkg::CMD_READ, $urandom, $urandom, $urandom_range(maxpos),
                          $urandom_range(maxpos), $urandom));
    else if (pick < 75)
      send_word(make_word(mcc_pkg::CMD_WR_PIX, $urandom, $urandom, $urandom, $urandom,
                          $urandom));
    else if (pick < 93)
      send_word(make_word(mcc_pkg::CMD_WR_WGT, $urandom, $urandom, $urandom, $urandom,
                          $urandom));
    else
      send_word(make_word(mcc_pkg::CMD_WR_BIAS, $urandom, $urandom, $urandom, $urandom,
                          $urandom));
  endtask

  task automatic set_layer(int ni, int no, int sz, int k, int s);
    write_reg(mcc_pkg::REG_IN_CH, ni);
    write_reg(mcc_pkg::REG_OUT_CH, no);
    write_reg(mcc_pkg::REG_IMAGE, sz);
    write_reg(mcc_pkg::REG_KERNEL, k);
    write_reg(mcc_pkg::REG_STRIDE, s);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: tiny values then extreme values for saturation
    fill_stores(300);
    drain();
    set_layer(4, 8, FILL_SIDE, 5, 1);
    send_word(make_word(mcc_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_word(make_word(mcc_pkg::CMD_READ, 3, 7, 3, 3, 16'hffff));
    send_word(make_word(mcc_pkg::CMD_READ, 0, 7, 4, 0, 0));   // row past output size
    send_word(make_word(mcc_pkg::CMD_READ, 0, 0, 31, 31, 0));
    send_word(make_word(mcc_pkg::CMD_WR_WGT, 0, 0, 7, 2, 16'h7fff)); // outside kernel store
    send_word(make_word(mcc_pkg::CMD_READ, 0, 0, 0, 0, 0));
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 5; r++)
        for (int k = 0; k < 5; k++) begin
          send_word(make_word(mcc_pkg::CMD_WR_WGT, c, 1, r, k, 16'h7fff));
          send_word(make_word(mcc_pkg::CMD_WR_PIX, c, 0, r, k, 16'h7fff));
        end
    send_word(make_word(mcc_pkg::CMD_WR_BIAS, 0, 1, 0, 0, 16'h7fff));
    send_word(make_word(mcc_pkg::CMD_READ, 0, 1, 0, 0, 0));    // overflow
    send_word(make_word(mcc_pkg::CMD_WR_BIAS, 0, 2, 0, 0, 16'h8000));
    send_word(make_word(mcc_pkg::CMD_READ, 0, 2, 0, 0, 0));    // most negative bias
    drain();
    set_layer(1, 1, 1, 1, 32);
    send_word(make_word(mcc_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_word(make_word(mcc_pkg::CMD_READ, 0, 1, 0, 0, 0));
    drain();
    // invalid settings
    set_layer(0, 9, 33, 6, 0);
    send_word(make_word(mcc_pkg::CMD_READ, 0, 0, 0, 0, 0));
    drain();
    set_layer(5, 0, 0, 7, 63);
    send_word(make_word(mcc_pkg::CMD_READ, 0, 0, 0, 0, 0));
    drain();
    set_layer(2, 4, 3, 4, 1);                          // kernel above image
    send_word(make_word(mcc_pkg::CMD_READ, 0, 0, 0, 0, 0));
    drain();

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 83 : 0;
      recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 14 : 0;
      for (int sub = 0; sub < 4; sub++) begin
        drain();
        if (sub == 0)
          set_layer(4, 8, FILL_SIDE, 5, 1);
        else
          set_layer($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(5, FILL_SIDE),
                    $urandom_range(1, 5), $urandom_range(1, 4));
        if (ph == 2 && sub == 1) begin
          fork
            begin
              hold_off = 1;
              repeat (400) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        for (int i = 0; i < 45; i++) random_word(sub == 3 ? 31 : 4);
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

>>> multichannel_conv2d_bias_relu_core.f
rtl/core/mcc_pkg.sv
rtl/core/mcc_ram.sv
rtl/core/mcc_front.sv
rtl/core/mcc_fifo.sv
rtl/core/mcc_back.sv
rtl/core/multichannel_conv2d_bias_relu_core.sv
tb/testbench.sv
